// ----- hw/rtl/dnn_pkg.sv -----
// Package for the domain name normaliser: phase codes, result type and character helpers.
`timescale 1ns / 1ps

package dnn_pkg;

	// Parsing phase of the current name
	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_BODY = 2'd1,
		PH_DOT  = 2'd2,
		PH_REJ  = 2'd3
	} phase_t;

	// Result kinds
	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Summary status codes
	localparam logic ST_OK  = 1'b0;
	localparam logic ST_BAD = 1'b1;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// One result item
	typedef struct packed {
		logic        kind;
		logic [7:0]  out_char;
		logic        status;
		logic [7:0]  name_length;
		logic [63:0] label_offsets;
		logic        last;
	} result_t;

	// Character class result: ok flag and the lowered character
	typedef struct packed {
		logic       ok;
		logic [7:0] ch;
	} map_t;

	function automatic map_t map_char(input logic [7:0] c);
		map_t m;
		m.ok = 1'b1;
		m.ch = c;
		if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_0 && c <= CH_9) ||
			c == CH_DASH || c == CH_UNDER) begin
			m.ch = c;
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			m.ch = c + CASE_OFS;
		end else begin
			m.ok = 1'b0;
		end
		return m;
	endfunction

	// Byte reversal of a 64-bit word
	function automatic logic [63:0] swap64(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = v[8*(7-i) +: 8];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/domain_name_normalizer_top.sv -----
// Top level of the domain name normaliser: byte classifier, name state and result queue.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, in_byte, end_of_name) takes one byte
// of a host name per item; end_of_name or a zero byte closes the name.
// The output channel (out_valid, out_stall, kind, out_char, status,
// name_length, label_offsets, last) gives character items (kind 0) and one
// summary item (kind 1) per name; last marks the final result of an input item.
// An input item is classified and the name state updated in the cycle it is
// accepted; its results are written into a four-entry result queue and are
// read out of that registered queue onto the output.
// Throughput is one input item per cycle while in_stall is low. An item gives
// up to two results (a pending dot plus a character, or a lone dot plus the
// summary), and the output drains one result per cycle while out_stall is low,
// so the queue depth sets how long bursts of two-result items run at full rate.
// in_stall rises when fewer than two queue entries are free, so a stalled
// receiver backs up into the input after three or four results.
// Reset empties the queue and puts the name state back to the start of a name.
module domain_name_normalizer_top
	import dnn_pkg::*;
#(
	parameter int MAX_LEN      = 255,
	parameter int OFFSET_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_name,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  out_char,
	output logic        status,
	output logic [7:0]  name_length,
	output logic [63:0] label_offsets,
	output logic        last
);

	localparam logic [7:0]  MAX_LEN_B = 8'(MAX_LEN);
	localparam logic [63:0] SLOT_MASK = ALL_ONES >> (64 - 8 * OFFSET_SLOTS);
	localparam int          QDEPTH    = 4;

	phase_t      phase_q, phase_d;
	logic        saw_q, saw_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [63:0] offs_q, offs_d;

	result_t     res0, res1;
	logic [1:0]  n_push;
	logic        in_acc, is_end, pop;
	map_t        mapped;
	logic [7:0]  cnt_mid;

	result_t     queue_q [QDEPTH];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  qcnt_q;

	assign in_acc = in_valid && !in_stall;
	assign is_end = end_of_name || (in_byte == CH_NUL);
	assign mapped = map_char(in_byte);

	// Per-byte classification and next name state
	always_comb begin
		phase_d = phase_q;
		saw_d   = saw_q;
		cnt_d   = cnt_q;
		offs_d  = offs_q;
		cnt_mid = cnt_q;
		n_push  = 2'd0;
		res0    = '0;
		res1    = '0;
		if (is_end) begin
			res0.kind          = KIND_SUMMARY;
			res0.label_offsets = ALL_ONES;
			if (phase_q == PH_LEAD) begin
				if (saw_q) begin
					// only dots: emit a lone dot before the summary
					res0.kind          = KIND_CHAR;
					res0.out_char      = CH_DOT;
					res0.label_offsets = '0;
					res1.kind          = KIND_SUMMARY;
					res1.status        = ST_OK;
					res1.name_length   = 8'd1;
					res1.label_offsets = ALL_ONES;
					n_push             = 2'd2;
				end else begin
					res0.status = ST_BAD;
					n_push      = 2'd1;
				end
			end else if (phase_q == PH_REJ) begin
				res0.status      = ST_BAD;
				res0.name_length = cnt_q;
				n_push           = 2'd1;
			end else begin
				res0.status        = ST_OK;
				res0.name_length   = cnt_q;
				res0.label_offsets = swap64(offs_q);
				n_push             = 2'd1;
			end
			phase_d = PH_LEAD;
			saw_d   = 1'b0;
			cnt_d   = '0;
			offs_d  = ALL_ONES;
		end else if (phase_q == PH_REJ) begin
			n_push = 2'd0;
		end else if (in_byte == CH_DOT) begin
			if (phase_q == PH_LEAD) begin
				saw_d = 1'b1;
			end else begin
				phase_d = PH_DOT;
			end
		end else begin
			// pending dot goes out first and opens a new label
			if (phase_q == PH_DOT) begin
				if (cnt_q >= MAX_LEN_B) begin
					phase_d = PH_REJ;
				end else begin
					cnt_mid       = cnt_q + 8'd1;
					res0.kind     = KIND_CHAR;
					res0.out_char = CH_DOT;
					n_push        = 2'd1;
					offs_d = (((offs_q << 8) | {56'd0, cnt_mid}) & SLOT_MASK) | ~SLOT_MASK;
					phase_d = PH_BODY;
				end
			end
			if (phase_d != PH_REJ) begin
				if (!mapped.ok) begin
					phase_d = PH_REJ;
				end else if (cnt_mid >= MAX_LEN_B) begin
					phase_d = PH_REJ;
				end else begin
					phase_d = PH_BODY;
					if (n_push == 2'd0) begin
						res0.kind     = KIND_CHAR;
						res0.out_char = mapped.ch;
					end else begin
						res1.kind     = KIND_CHAR;
						res1.out_char = mapped.ch;
					end
					n_push = n_push + 2'd1;
				end
			end
			// every result of a name byte is one character
			cnt_d = cnt_q + {6'd0, n_push};
		end
		res0.last = (n_push == 2'd1);
		res1.last = (n_push == 2'd2);
	end

	// Name state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			saw_q   <= 1'b0;
			cnt_q   <= '0;
			offs_q  <= ALL_ONES;
		end else if (in_acc) begin
			phase_q <= phase_d;
			saw_q   <= saw_d;
			cnt_q   <= cnt_d;
			offs_q  <= offs_d;
		end
	end

	// Result queue: up to two writes and one read per cycle
	assign out_valid = (qcnt_q != 3'd0);
	assign pop       = out_valid && !out_stall;
	assign in_stall  = (qcnt_q > 3'(QDEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			qcnt_q <= '0;
		end else begin
			if (in_acc) begin
				wr_q <= wr_q + n_push;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			qcnt_q <= qcnt_q + (in_acc ? {1'b0, n_push} : 3'd0) - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && n_push != 2'd0) begin
			queue_q[wr_q] <= res0;
		end
		if (in_acc && n_push == 2'd2) begin
			queue_q[wr_q + 2'd1] <= res1;
		end
	end

	assign kind          = queue_q[rd_q].kind;
	assign out_char      = queue_q[rd_q].out_char;
	assign status        = queue_q[rd_q].status;
	assign name_length   = queue_q[rd_q].name_length;
	assign label_offsets = queue_q[rd_q].label_offsets;
	assign last          = queue_q[rd_q].last;

	// Checks
	a_qcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= 3'(QDEPTH))
		else $error("result queue overfilled");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_end |=> phase_q == PH_LEAD && cnt_q == 8'd0 && !saw_q)
		else $error("name state not cleared after end of name");

	a_rej_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !is_end && phase_q == PH_REJ |-> n_push == 2'd0)
		else $error("rejected name produced a result");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_LEN_B)
		else $error("name length beyond limit");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CHAR |-> status == ST_OK && label_offsets == 64'd0)
		else $error("character item carries summary fields");

endmodule

// ----- dv/domain_name_normalizer_top_test.sv -----
// Testbench for the domain name normaliser: random host names against an in-bench predictor.
`timescale 1ns / 1ps

module domain_name_normalizer_top_test;
	import dnn_pkg::*;

	localparam int NAME_MAX     = 255;
	localparam int SLOTS        = 8;
	localparam int RANDOM_ITEMS = 2000;
	localparam int IDLE_LIMIT   = 2000;

	// One input item: a byte of the name and the end flag
	typedef struct packed {
		logic [7:0] b;
		logic       eon;
	} name_item_t;

	// Predicts the normalised characters and summaries, then checks them
	class name_scoreboard;
		result_t     pending_results[$];
		result_t     batch[$];
		int          errors;
		phase_t      phase;
		bit          lead_dot;
		logic [7:0]  char_count;
		logic [63:0] label_reg;

		function new();
			errors = 0;
			restart_name();
		endfunction

		function void restart_name();
			phase      = PH_LEAD;
			lead_dot   = 1'b0;
			char_count = 8'd0;
			label_reg  = ALL_ONES;
		endfunction

		function void add_result(logic k, logic [7:0] ch, logic st, logic [7:0] len,
			logic [63:0] offs);
			result_t r;
			r.kind          = k;
			r.out_char      = ch;
			r.status        = st;
			r.name_length   = len;
			r.label_offsets = offs;
			r.last          = 1'b0;
			batch.push_back(r);
		endfunction

		// Emits a character unless the name is already at full length
		function bit add_char(logic [7:0] ch);
			if (char_count >= 8'(NAME_MAX)) begin
				phase = PH_REJ;
				return 1'b0;
			end
			char_count++;
			add_result(KIND_CHAR, ch, ST_OK, 8'd0, 64'd0);
			return 1'b1;
		endfunction

		// Lowers upper-case letters; returns 0 for bytes not allowed in a name
		function bit lower_char(input logic [7:0] c, output logic [7:0] m);
			m = c;
			if (c >= CH_UP_A && c <= CH_UP_Z) begin
				m = c | 8'h20;
				return 1'b1;
			end
			return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_0 && c <= CH_9) ||
				c == CH_DASH || c == CH_UNDER;
		endfunction

		// Works out the results of one accepted item; returns 0 if it is ignored
		function bit take_byte(logic [7:0] b, logic eon);
			logic [7:0]  m;
			logic [63:0] mask;
			logic [63:0] swapped;
			bit          ok;
			batch.delete();
			mask = (SLOTS >= 8) ? ALL_ONES : ((64'd1 << (8 * SLOTS)) - 64'd1);
			if (eon || b == CH_NUL) begin
				case (phase)
				PH_LEAD: begin
					if (lead_dot) begin
						add_result(KIND_CHAR, CH_DOT, ST_OK, 8'd0, 64'd0);
						add_result(KIND_SUMMARY, 8'd0, ST_OK, 8'd1, ALL_ONES);
					end else begin
						add_result(KIND_SUMMARY, 8'd0, ST_BAD, 8'd0, ALL_ONES);
					end
				end
				PH_REJ: add_result(KIND_SUMMARY, 8'd0, ST_BAD, char_count, ALL_ONES);
				default: begin
					swapped = {<<8{label_reg}};
					add_result(KIND_SUMMARY, 8'd0, ST_OK, char_count, swapped);
				end
				endcase
				restart_name();
			end else if (phase == PH_REJ) begin
				return 1'b0;
			end else if (b == CH_DOT) begin
				if (phase == PH_LEAD)
					lead_dot = 1'b1;
				else
					phase = PH_DOT;
			end else begin
				ok = 1'b1;
				// pending dot goes out first and opens a new label
				if (phase == PH_DOT) begin
					ok = add_char(CH_DOT);
					if (ok) begin
						label_reg = (((label_reg << 8) | {56'd0, char_count}) & mask) | ~mask;
						phase = PH_BODY;
					end
				end
				if (ok) begin
					if (!lower_char(b, m))
						phase = PH_REJ;
					else if (add_char(m))
						phase = PH_BODY;
				end
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				pending_results.push_back(batch[i]);
			return 1'b1;
		endfunction

		task report(string field, logic [63:0] seen_v, logic [63:0] want_v);
			$display("%0t: mismatch in %s: got %h, want %h", $time, field, seen_v, want_v);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report("unexpected result", 64'({got.kind, got.out_char}), 64'd0);
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind)
				report("kind", 64'(got.kind), 64'(want.kind));
			if (got.out_char !== want.out_char)
				report("out_char", 64'(got.out_char), 64'(want.out_char));
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
			if (got.name_length !== want.name_length)
				report("name_length", 64'(got.name_length), 64'(want.name_length));
			if (got.label_offsets !== want.label_offsets)
				report("label_offsets", got.label_offsets, want.label_offsets);
			if (got.last !== want.last)
				report("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        end_of_name;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  out_char;
	logic        status;
	logic [7:0]  name_length;
	logic [63:0] label_offsets;
	logic        last;

	name_scoreboard sb;
	name_item_t     script[$];
	int             useful_items;
	bit             calm_in;
	bit             calm_out;

	domain_name_normalizer_top #(
		.MAX_LEN      (NAME_MAX),
		.OFFSET_SLOTS (SLOTS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_name   (end_of_name),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.out_char      (out_char),
		.status        (status),
		.name_length   (name_length),
		.label_offsets (label_offsets),
		.last          (last)
	);

	always #6 clk = ~clk;

	// Mostly no gap, some short, a few long
	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(0, 63);
		if (r < 26)
			return CH_LO_A + 8'(r);
		if (r < 52)
			return CH_UP_A + 8'(r - 26);
		if (r < 62)
			return CH_0 + 8'(r - 52);
		return (r == 62) ? CH_DASH : CH_UNDER;
	endfunction

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		logic [7:0] m;
		c = 8'($urandom_range(1, 255));
		while (c == CH_DOT || sb.lower_char(c, m))
			c = 8'($urandom_range(1, 255));
		return c;
	endfunction

	function automatic void push_byte(logic [7:0] b, logic eon = 1'b0);
		name_item_t it;
		it.b   = b;
		it.eon = eon;
		script.push_back(it);
	endfunction

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	// Sends one item after a random gap and waits for it to be taken
	task automatic send_item(name_item_t it);
		int gap;
		gap = pick_gap(calm_in);
		if (gap > 0) begin
			@(negedge clk);
			in_valid    <= 1'b0;
			in_byte     <= 8'($urandom);
			end_of_name <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		in_byte     <= it.b;
		end_of_name <= it.eon;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (sb.take_byte(it.b, it.eon))
			useful_items++;
	endtask

	task automatic run_script();
		foreach (script[i])
			send_item(script[i]);
		script.delete();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One random name: mostly well formed, some corrupt, only dots, noise or near the length limit
	task automatic build_random_name();
		int pick;
		int labels;
		int len;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 93 && !(pick >= 70 && pick < 78)) begin
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) push_byte(CH_DOT);
			labels = $urandom_range(1, 12);
			for (int l = 0; l < labels; l++) begin
				if (l > 0)
					repeat (($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 1)
						push_byte(CH_DOT);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
				repeat (len) push_byte(name_char());
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 2)) push_byte(CH_DOT);
			// corrupt name: a bad byte somewhere, then some bytes to be ignored
			if (pick >= 78) begin
				n = $urandom_range(0, script.size());
				script.insert(n, name_item_t'({bad_char(), 1'b0}));
				repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(1, 255)));
			end
		end else if (pick < 78) begin
			repeat ($urandom_range(0, 4)) push_byte(CH_DOT);
		end else if (pick < 97) begin
			repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
		end else begin
			// around the length limit
			case ($urandom_range(0, 3))
			0: n = NAME_MAX - 1;
			1: n = NAME_MAX;
			2: n = NAME_MAX + 1;
			default: n = $urandom_range(NAME_MAX - 15, NAME_MAX + 45);
			endcase
			for (int i = 0; i < n; i++)
				push_byte((i > 0 && $urandom_range(0, 11) == 0) ? CH_DOT : name_char());
		end
		if ($urandom_range(0, 1))
			push_byte(8'($urandom_range(0, 255)), 1'b1);
		else
			push_byte(CH_NUL);
	endtask

	// Result sink with random stalls
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm_out || $urandom_range(0, 99) < 65) begin
				out_stall <= 1'b0;
				hold = $urandom_range(1, 8);
			end else begin
				out_stall <= 1'b1;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			end
			repeat (hold - 1) @(negedge clk);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_t'({kind, out_char, status, name_length, label_offsets, last}));
	end

	// Watchdog on cycles with no item moving on either side
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Main sequence
	initial begin
		sb          = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_byte     = 8'd0;
		end_of_name = 1'b0;
		calm_in     = 1'b0;
		calm_out    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty name
		push_byte(8'hFF, 1'b1);
		// only dots, closed by a zero byte
		push_str("..");
		push_byte(CH_NUL);
		// leading dot, case extremes, dot run, digits, dash, underscore, trailing dots
		push_str(".AZ..az09-_..");
		push_byte(CH_NUL, 1'b1);
		// dot then bad byte, then an ignored byte
		push_str("a.@x");
		push_byte(8'h80, 1'b1);
		run_script();
		wait_drained();

		useful_items = 0;
		while (useful_items < RANDOM_ITEMS) begin
			calm_in  = ($urandom_range(0, 9) == 0);
			calm_out = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 19) == 0)
				wait_drained();
			build_random_name();
			run_script();
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
